@@ rtl/window_range_edge_threshold_macros.svh @@
// Assertion macros for the window range edge threshold block.
// Taken in by the top level; no other dependencies.
`ifndef WINDOW_RANGE_EDGE_THRESHOLD_MACROS_SVH
`define WINDOW_RANGE_EDGE_THRESHOLD_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WRET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define WRET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wret_pkg.sv @@
// Shared types and constants for the window range edge threshold block.
// No dependencies; used by the channel interfaces and the top level.
package wret_pkg;

   localparam int PIXEL_W       = 8;
   localparam int THRESHOLD_W   = 8;
   localparam int LINE_WIDTH_W  = 11;
   localparam int ROW_W         = 12;
   localparam int OUT_COL_W     = 10;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 12;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MIN_DIM            = 3;
   localparam int THRESHOLD_RESET    = 0;
   localparam int LINE_WIDTH_RESET   = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_LINE_WIDTH   = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

endpackage

@@ rtl/wret_ifs.sv @@
// Valid/ready channel interfaces for pixel words in and result words out.
// Depends on wret_pkg for the field widths.
interface wret_req_if;
   logic                         valid;
   logic                         ready;
   logic [wret_pkg::PIXEL_W-1:0] pixel;
   logic                         frame_start;

   modport source(output valid, pixel, frame_start, input ready);
   modport sink(input valid, pixel, frame_start, output ready);
endinterface

interface wret_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wret_pkg::PIXEL_W-1:0]   edge_value;
   logic [wret_pkg::ROW_W-1:0]     out_row;
   logic [wret_pkg::OUT_COL_W-1:0] out_col;
   logic                           frame_last;

   modport source(output valid, edge_value, out_row, out_col, frame_last, input ready);
   modport sink(input valid, edge_value, out_row, out_col, frame_last, output ready);
endinterface

@@ rtl/window_range_edge_threshold.sv @@
// Top level of the 3x3 window range edge detector with two line stores.
// Depends on wret_pkg, the channel interfaces and the assertion macro header.
//
// One pixel word is accepted per clock, back to back, while the output
// register can take a word or the window stage holds no result of its own.
// Each line store is a single memory with one read and one write per cycle:
// the read is issued when the pixel word is accepted and the write-back of the
// shifted column follows when the word leaves the window stage, with a bypass
// for a read of the column just written. The result word for an accepted pixel
// passes the pixel stage, the window stage and the output register. Pixels in
// row 0 or column 0 give no result word, so a frame of H rows and W columns
// yields (H-1)*(W-1) words. There is no clearing pass after reset.
`include "window_range_edge_threshold_macros.svh"

module window_range_edge_threshold #(
   parameter int MAX_WIDTH = wret_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   wret_req_if.sink                          req_ch,
   wret_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [wret_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wret_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int RW  = wret_pkg::ROW_W;
   localparam int PW  = wret_pkg::PIXEL_W;
   localparam int TW  = wret_pkg::THRESHOLD_W;
   localparam int LWW = wret_pkg::LINE_WIDTH_W;
   localparam int OCW = wret_pkg::OUT_COL_W;

   localparam logic [WW-1:0] W_RESET = WW'((wret_pkg::LINE_WIDTH_RESET > MAX_WIDTH) ?
                                           MAX_WIDTH : wret_pkg::LINE_WIDTH_RESET);
   localparam logic [WW-1:0] W_MAX   = WW'(MAX_WIDTH);
   localparam logic [WW-1:0] W_MIN   = WW'(wret_pkg::MIN_DIM);
   localparam logic [RW-1:0] H_RESET = RW'(wret_pkg::FRAME_HEIGHT_RESET);
   localparam logic [RW-1:0] H_MIN   = RW'(wret_pkg::MIN_DIM);
   localparam logic [TW-1:0] T_RESET = TW'(wret_pkg::THRESHOLD_RESET);

   function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // Configuration, kept in its effective (clamped) form.
   logic [TW-1:0] threshold_ff;
   logic [WW-1:0] eff_w_ff, eff_w_in;
   logic [RW-1:0] eff_h_ff, eff_h_in;
   logic [LWW-1:0] lw_wr;
   logic [RW-1:0]  fh_wr;

   // Raster position of the next pixel word.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Pixel stage.
   logic          adv_out, adv, accept;
   logic [CW-1:0] col_base, col_c;
   logic [RW-1:0] row_base, row_b, row_c, row_n;
   logic [WW-1:0] col_n;
   logic          emit_c, inner_c, last_c;

   // Line stores and their registered read data.
   logic [PW-1:0] upper_mem [MAX_WIDTH];
   logic [PW-1:0] middle_mem [MAX_WIDTH];
   logic [PW-1:0] rd_upper_ff, rd_middle_ff;

   // Window stage.
   logic          s1_valid_ff, s1_emit_ff, s1_inner_ff, s1_last_ff;
   logic [PW-1:0] s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          s1_leave, bypass;
   logic [PW-1:0] above2, above1, ncol_max, ncol_min, win_max, win_min, win_range;
   logic          edge_hit;

   // Last write-back, used to bypass a read of the same column.
   logic          wb_valid_ff;
   logic [CW-1:0] wb_col_ff;
   logic [PW-1:0] wb_above1_ff, wb_pix_ff;

   // Per-column max and min of the two older window columns.
   logic [PW-1:0] cmax1_ff, cmin1_ff, cmax2_ff, cmin2_ff;

   // Output register.
   logic           rsp_valid_ff, rsp_last_ff;
   logic [PW-1:0]  rsp_edge_ff;
   logic [RW-1:0]  rsp_row_ff;
   logic [OCW-1:0] rsp_col_ff;

   // ---------------------------------------------------------------- config
   assign lw_wr = csr_wdata[LWW-1:0];
   assign fh_wr = csr_wdata[RW-1:0];

   always_comb begin
      if (lw_wr < LWW'(wret_pkg::MIN_DIM)) begin
         eff_w_in = W_MIN;
      end else if (32'(lw_wr) > MAX_WIDTH) begin
         eff_w_in = W_MAX;
      end else begin
         eff_w_in = WW'(lw_wr);
      end
      eff_h_in = (fh_wr < H_MIN) ? H_MIN : fh_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= T_RESET;
         eff_w_ff     <= W_RESET;
         eff_h_ff     <= H_RESET;
      end else if (csr_we) begin
         case (csr_index)
            wret_pkg::CSR_THRESHOLD:    threshold_ff <= csr_wdata[TW-1:0];
            wret_pkg::CSR_LINE_WIDTH:   eff_w_ff     <= eff_w_in;
            wret_pkg::CSR_FRAME_HEIGHT: eff_h_ff     <= eff_h_in;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ pixel stage
   assign adv_out = !rsp_valid_ff || rsp_ch.ready;
   // The window stage may move on whenever its word produces no result.
   assign adv     = adv_out || !s1_valid_ff || !s1_emit_ff;
   assign accept  = req_ch.valid && adv;
   assign req_ch.ready = adv;

   always_comb begin
      col_base = req_ch.frame_start ? '0 : col_ff;
      row_base = req_ch.frame_start ? '0 : row_ff;
      // A position left outside the geometry by a configuration change
      // starts the next row, and a row outside it starts a new frame.
      if (WW'(col_base) >= eff_w_ff) begin
         col_c = '0;
         row_b = row_base + 1'b1;
      end else begin
         col_c = col_base;
         row_b = row_base;
      end
      row_c = (row_b >= eff_h_ff) ? '0 : row_b;

      col_n = WW'(col_c) + 1'b1;
      row_n = row_c;
      if (col_n >= eff_w_ff) begin
         col_n = '0;
         row_n = row_c + 1'b1;
      end
      if (row_n >= eff_h_ff) begin
         row_n = '0;
      end
      col_in = CW'(col_n);
      row_in = row_n;

      emit_c  = (row_c != '0) && (col_c != '0);
      inner_c = (row_c >= RW'(2)) && (col_c >= CW'(2));
      last_c  = (row_c == eff_h_ff - 1'b1) && (WW'(col_c) == eff_w_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_ch.pixel;
         s1_col_ff   <= col_c;
         s1_row_ff   <= row_c;
         s1_emit_ff  <= emit_c;
         s1_inner_ff <= inner_c;
         s1_last_ff  <= last_c;
      end
   end

   // ------------------------------------------------------------ line stores
   assign s1_leave = adv && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         upper_mem[s1_col_ff] <= above1;
      end
      if (accept) begin
         rd_upper_ff <= upper_mem[col_c];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         middle_mem[s1_col_ff] <= s1_pix_ff;
      end
      if (accept) begin
         rd_middle_ff <= middle_mem[col_c];
      end
   end

   // ----------------------------------------------------------- window stage
   // A read issued in the same cycle as the write-back of the same column
   // returns the old word, so the last write-back is used instead.
   assign bypass = wb_valid_ff && (wb_col_ff == s1_col_ff);
   assign above2 = bypass ? wb_above1_ff : rd_upper_ff;
   assign above1 = bypass ? wb_pix_ff    : rd_middle_ff;

   always_comb begin
      ncol_max  = max2(max2(above2, above1), s1_pix_ff);
      ncol_min  = min2(min2(above2, above1), s1_pix_ff);
      win_max   = max2(max2(ncol_max, cmax1_ff), cmax2_ff);
      win_min   = min2(min2(ncol_min, cmin1_ff), cmin2_ff);
      win_range = win_max - win_min;
      edge_hit  = s1_inner_ff && (win_range > threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (s1_leave) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         wb_col_ff    <= s1_col_ff;
         wb_above1_ff <= above1;
         wb_pix_ff    <= s1_pix_ff;
         cmax2_ff     <= cmax1_ff;
         cmin2_ff     <= cmin1_ff;
         cmax1_ff     <= ncol_max;
         cmin1_ff     <= ncol_min;
      end
   end

   // -------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && s1_valid_ff && s1_emit_ff) begin
         rsp_edge_ff <= edge_hit ? wret_pkg::EDGE_ON : wret_pkg::EDGE_OFF;
         rsp_row_ff  <= s1_row_ff - 1'b1;
         rsp_col_ff  <= OCW'(s1_col_ff - 1'b1);
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.edge_value = rsp_edge_ff;
   assign rsp_ch.out_row    = rsp_row_ff;
   assign rsp_ch.out_col    = rsp_col_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

   // ------------------------------------------------------------- assertions
   `WRET_ASSERT_NEXT(a_position_in_frame, clock, reset, accept && !csr_we, (WW'(col_ff) < eff_w_ff) && (row_ff < eff_h_ff), "raster position left the frame geometry")
   `WRET_ASSERT_NOW(a_border_is_zero, clock, reset, rsp_valid_ff && ((rsp_row_ff == '0) || (rsp_col_ff == '0)), rsp_edge_ff == wret_pkg::EDGE_OFF, "border result word is not zero")
   `WRET_ASSERT_NEXT(a_window_stage_holds, clock, reset, s1_valid_ff && !adv, s1_valid_ff && $stable(s1_col_ff) && $stable(s1_pix_ff), "stalled window stage lost its word")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the 3x3 window range edge detector.
// Depends on wret_pkg, the wret_req_if/wret_rsp_if channel interfaces and the
// window_range_edge_threshold top level.
module tb_top;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_ITEMS    = 700;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WIDE_ROW_EXTRA  = 64;
   localparam int SMALL_FRAMES    = 4;

   localparam int PW        = wret_pkg::PIXEL_W;
   localparam int TW        = wret_pkg::THRESHOLD_W;
   localparam int LWW       = wret_pkg::LINE_WIDTH_W;
   localparam int RW        = wret_pkg::ROW_W;
   localparam int OCW       = wret_pkg::OUT_COL_W;
   localparam int IW        = wret_pkg::CSR_INDEX_W;
   localparam int DW        = wret_pkg::CSR_DATA_W;
   localparam int COL_IDX_W = $clog2(wret_pkg::MAX_WIDTH_DEFAULT);

   localparam logic [PW-1:0] DIRECTED_PIXELS [24] = '{
      10, 10, 10, 10,
      10, 60, 10, 10,
      10, 10, 61, 10,
      0, 255, 10, 10,
      255, 0, 255, 0,
      1, 2, 3, 4
   };

   typedef struct packed {
      logic [PW-1:0]  edge_value;
      logic [RW-1:0]  out_row;
      logic [OCW-1:0] out_col;
      logic           frame_last;
   } edge_word_type;

   // Tracks the line stores, the window and the raster position, and holds the
   // result words still owed by the block.
   class edge_tracker_type;
      logic [TW-1:0]   threshold;
      logic [LWW-1:0]  line_width;
      logic [RW-1:0]   frame_height;
      logic [PW-1:0]   upper_line [wret_pkg::MAX_WIDTH_DEFAULT];
      logic [PW-1:0]   middle_line [wret_pkg::MAX_WIDTH_DEFAULT];
      logic [PW-1:0]   window [9];
      int unsigned     col_count;
      int unsigned     row_count;
      edge_word_type   expected_edges [$];
      int              error_count;

      function new();
         threshold    = TW'(wret_pkg::THRESHOLD_RESET);
         line_width   = LWW'(wret_pkg::LINE_WIDTH_RESET);
         frame_height = RW'(wret_pkg::FRAME_HEIGHT_RESET);
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
         col_count   = 0;
         row_count   = 0;
         error_count = 0;
      endfunction

      function void write_register(wret_pkg::csr_index_type idx, logic [DW-1:0] value);
         case (idx)
            wret_pkg::CSR_THRESHOLD:    threshold    = value[TW-1:0];
            wret_pkg::CSR_LINE_WIDTH:   line_width   = value[LWW-1:0];
            wret_pkg::CSR_FRAME_HEIGHT: frame_height = value[RW-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned active_width();
         if (32'(line_width) < wret_pkg::MIN_DIM) return wret_pkg::MIN_DIM;
         if (32'(line_width) > wret_pkg::MAX_WIDTH_DEFAULT)
            return wret_pkg::MAX_WIDTH_DEFAULT;
         return 32'(line_width);
      endfunction

      function void note_pixel(logic [PW-1:0] pix, logic frame_start);
         int unsigned           w, h, row, col;
         logic [COL_IDX_W-1:0]  ci;
         logic [PW-1:0]         above2, above1, hi, lo;
         edge_word_type         word;
         w = active_width();
         h = (32'(frame_height) < wret_pkg::MIN_DIM) ? wret_pkg::MIN_DIM
                                                     : 32'(frame_height);
         row = frame_start ? 0 : row_count;
         col = frame_start ? 0 : col_count;
         // A geometry that shrank under the counters wraps to the next row or frame.
         if (col >= w) begin
            col = 0;
            row++;
         end
         if (row >= h) row = 0;

         ci = COL_IDX_W'(col);
         above2 = upper_line[ci];
         above1 = middle_line[ci];
         upper_line[ci]  = above1;
         middle_line[ci] = pix;
         for (int k = 0; k < 9; k += 3) begin
            window[k]     = window[k + 1];
            window[k + 1] = window[k + 2];
         end
         window[2] = above2;
         window[5] = above1;
         window[8] = pix;

         col_count = col + 1;
         row_count = row;
         if (col_count >= w) begin
            col_count = 0;
            row_count++;
         end
         if (row_count >= h) row_count = 0;

         if (row >= 1 && col >= 1) begin
            word.edge_value = wret_pkg::EDGE_OFF;
            if (row >= 2 && col >= 2) begin
               hi = window[0];
               lo = window[0];
               for (int k = 1; k < 9; k++) begin
                  if (window[k] > hi) hi = window[k];
                  if (window[k] < lo) lo = window[k];
               end
               if (hi - lo > threshold) word.edge_value = wret_pkg::EDGE_ON;
            end
            word.out_row    = RW'(row - 1);
            word.out_col    = OCW'(col - 1);
            word.frame_last = (row == h - 1) && (col == w - 1);
            expected_edges.push_back(word);
         end
      endfunction

      function void compare_field(string name, logic [RW-1:0] want, logic [RW-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_edge(edge_word_type got);
         edge_word_type want;
         if (expected_edges.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual value %0d row %0d col %0d",
                     $time, got.edge_value, got.out_row, got.out_col);
            error_count++;
            return;
         end
         want = expected_edges.pop_front();
         compare_field("edge_value", RW'(want.edge_value), RW'(got.edge_value));
         compare_field("out_row", want.out_row, got.out_row);
         compare_field("out_col", RW'(want.out_col), RW'(got.out_col));
         compare_field("frame_last", RW'(want.frame_last), RW'(got.frame_last));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [IW-1:0]    csr_index;
   logic [DW-1:0]    csr_wdata;
   bit               hold_off_request = 1'b0;
   int               burst_left = 0;
   edge_tracker_type tracker;

   wret_req_if req_if();
   wret_rsp_if rsp_if();

   window_range_edge_threshold dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic write_register(wret_pkg::csr_index_type idx, logic [DW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_register(idx, value);
      @(posedge clock);
   endtask

   // Offers one pixel word and returns once it has been taken. The sender runs
   // in bursts, with idle gaps between some of them.
   task automatic send_pixel(logic [PW-1:0] pix, logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.pixel       <= pix;
      req_if.frame_start <= start;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_pixel(pix, start);
   endtask

   function automatic logic [PW-1:0] pick_pixel(int base, int spread);
      int v;
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(0, 1) ? wret_pkg::EDGE_ON : wret_pkg::EDGE_OFF;
      v = base + $urandom_range(0, spread);
      return (v > 255) ? 8'd255 : v[PW-1:0];
   endfunction

   task automatic run_pixels(int count, logic first_start, int base, int spread);
      for (int i = 0; i < count; i++)
         send_pixel(pick_pixel(base, spread),
                    (i == 0) ? first_start : ($urandom_range(0, 299) == 0));
   endtask

   // Waits until every owed result word has come out, then lets the pipeline
   // settle so that a register write cannot hit a pixel still in flight.
   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int             random_count, count, old_width;
      logic           restart;
      logic [LWW-1:0] width_value;
      logic [RW-1:0]  height_value;

      tracker            = new();
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.pixel       <= '0;
      req_if.frame_start <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= wret_pkg::CSR_THRESHOLD;
      csr_wdata          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Small 4x4 frames: window ranges of one above the threshold and more, a
      // wrap into the next frame without a start flag, and a restart mid-row.
      write_register(wret_pkg::CSR_THRESHOLD, 50);
      write_register(wret_pkg::CSR_LINE_WIDTH, 4);
      write_register(wret_pkg::CSR_FRAME_HEIGHT, 4);
      for (int i = 0; i < 24; i++)
         send_pixel(DIRECTED_PIXELS[i], (i == 0) || (i == 22));
      drain();

      // Widest row (an oversized width clamps) in the tallest frame: one full
      // row and the start of the next one.
      write_register(wret_pkg::CSR_THRESHOLD, 0);
      write_register(wret_pkg::CSR_LINE_WIDTH, 2047);
      write_register(wret_pkg::CSR_FRAME_HEIGHT, 4095);
      run_pixels(wret_pkg::MAX_WIDTH_DEFAULT + WIDE_ROW_EXTRA, 1'b1, 100, 2);
      drain();

      // Narrowest row and lowest frame (both clamp up), over several frames.
      write_register(wret_pkg::CSR_THRESHOLD, 254);
      write_register(wret_pkg::CSR_LINE_WIDTH, 0);
      write_register(wret_pkg::CSR_FRAME_HEIGHT, 2);
      run_pixels(SMALL_FRAMES * wret_pkg::MIN_DIM * wret_pkg::MIN_DIM, 1'b1, 0, 255);
      drain();

      random_count     = 0;
      hold_off_request = 1'b1;
      while (random_count < RANDOM_ITEMS) begin
         old_width = tracker.active_width();
         if ($urandom_range(0, 1))
            case ($urandom_range(0, 5))
               0:       write_register(wret_pkg::CSR_THRESHOLD, 0);
               1:       write_register(wret_pkg::CSR_THRESHOLD, 255);
               default: write_register(wret_pkg::CSR_THRESHOLD, DW'($urandom_range(0, 255)));
            endcase
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0:       width_value = LWW'($urandom_range(0, 2));
               1:       width_value = LWW'($urandom_range(1025, 2047));
               2:       width_value = LWW'(wret_pkg::MAX_WIDTH_DEFAULT);
               3:       width_value = LWW'(wret_pkg::MIN_DIM);
               default: width_value = LWW'($urandom_range(4, 12));
            endcase
            write_register(wret_pkg::CSR_LINE_WIDTH, DW'(width_value));
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
               0:       height_value = RW'($urandom_range(0, 2));
               1:       height_value = 4095;
               2:       height_value = RW'($urandom_range(9, 4095));
               default: height_value = RW'($urandom_range(3, 8));
            endcase
            write_register(wret_pkg::CSR_FRAME_HEIGHT, height_value);
         end
         // A row that grows mid-frame would read line store columns that the
         // rows above never filled, so a wider geometry always restarts the frame.
         restart = (tracker.active_width() > old_width) || ($urandom_range(0, 3) == 0);
         count   = $urandom_range(30, 400);
         run_pixels(count, restart, $urandom_range(0, 255), $urandom_range(0, 255));
         random_count += count;
         drain();
      end

      if (tracker.error_count == 0 && tracker.expected_edges.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Result side: ready follows a pattern that changes every so often, and once
   // it holds off long enough for the block to back up into its input.
   initial begin
      int mode, mode_left, hold_left, beat;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      beat      = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         beat++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               2:       rsp_if.ready <= (beat % 3 != 0);
               default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_edge({rsp_if.edge_value, rsp_if.out_row, rsp_if.out_col,
                             rsp_if.frame_last});
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

endmodule
